// ===== design/crc8wc_pkg.sv =====
// shared types, constants and crc helper for the crc-8 word response checker
`timescale 1ns / 1ps
package crc8wc_pkg;

  localparam int unsigned MaxWords = 16;
  localparam int unsigned CntW     = $clog2(MaxWords);
  localparam int unsigned NumW     = CntW + 1;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;

  localparam logic [7:0]       CrcPoly     = 8'h31;
  localparam logic [7:0]       CrcStart    = 8'hFF;
  localparam logic [15:0]      ErasedWord  = 16'hFFFF;
  localparam logic [7:0]       ErasedCheck = 8'hFF;
  localparam logic [4:0]       WprReset    = 5'd2;
  localparam logic [4:0]       WprCap      = (MaxWords < 16) ? 5'(MaxWords) : 5'd16;
  localparam logic [AddrW-1:0] AddrWpr     = AddrW'(0);

  typedef enum logic [1:0] {
    PH_HIGH  = 2'd0,
    PH_LOW   = 2'd1,
    PH_CHECK = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } in_req_t;

  typedef struct packed {
    logic [15:0]     word_value;
    logic [CntW-1:0] word_index;
    logic            crc_ok;
    logic            last_word;
  } res_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/crc8wc_in_stage.sv =====
// input register stage for incoming response bytes
`timescale 1ns / 1ps
module crc8wc_in_stage import crc8wc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  in_req_t req_i,
  input  logic    advance_i,
  output logic    valid_o,
  output in_req_t req_o
);

  logic    valid_q, valid_d;
  in_req_t req_q, req_d;
  logic    accept;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    req_d   = req_q;
    if (accept) begin
      valid_d = 1'b1;
      req_d   = req_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

// ===== design/crc8wc_frame.sv =====
// framing state, running crc and word check
`timescale 1ns / 1ps
module crc8wc_frame import crc8wc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  in_req_t    req_i,
  input  logic [4:0] wpr_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            disc_q, disc_d;
  logic [7:0]      high_q, high_d;
  logic [7:0]      low_q, low_d;
  logic [7:0]      crc_q, crc_d;

  phase_e          phase_eff;
  logic [CntW-1:0] cnt_eff;
  logic            disc_eff;
  logic [4:0]      n_eff;
  logic            final_word;
  logic            ok;

  always_comb begin
    if (wpr_i == 5'd0) begin
      n_eff = 5'd1;
    end else if (wpr_i > WprCap) begin
      n_eff = WprCap;
    end else begin
      n_eff = wpr_i;
    end
  end

  assign phase_eff  = req_i.restart ? PH_HIGH : phase_q;
  assign cnt_eff    = req_i.restart ? '0 : cnt_q;
  assign disc_eff   = req_i.restart ? 1'b0 : disc_q;
  assign final_word = (5'(cnt_eff) + 5'd1) >= n_eff;
  assign ok         = (crc_q == req_i.rx_byte)
                   || ({high_q, low_q} == ErasedWord && req_i.rx_byte == ErasedCheck);

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    disc_d      = disc_q;
    high_d      = high_q;
    low_d       = low_q;
    crc_d       = crc_q;
    res_valid_o = 1'b0;
    res_o.word_value = {high_q, low_q};
    res_o.word_index = cnt_eff;
    res_o.crc_ok     = ok;
    res_o.last_word  = final_word || !ok;
    case (phase_eff)
      PH_LOW: begin
        low_d   = req_i.rx_byte;
        crc_d   = crc8_byte(crc_q, req_i.rx_byte);
        phase_d = PH_CHECK;
        cnt_d   = cnt_eff;
        disc_d  = disc_eff;
      end
      PH_CHECK: begin
        phase_d     = PH_HIGH;
        res_valid_o = !disc_eff;
        if (final_word) begin
          cnt_d  = '0;
          disc_d = 1'b0;
        end else begin
          cnt_d  = cnt_eff + 1'b1;
          disc_d = disc_eff || !ok;
        end
      end
      default: begin
        high_d  = req_i.rx_byte;
        crc_d   = crc8_byte(CrcStart, req_i.rx_byte);
        phase_d = PH_LOW;
        cnt_d   = cnt_eff;
        disc_d  = disc_eff;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HIGH;
      cnt_q   <= '0;
      disc_q  <= 1'b0;
      high_q  <= '0;
      low_q   <= '0;
      crc_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      disc_q  <= disc_d;
      high_q  <= high_d;
      low_q   <= low_d;
      crc_q   <= crc_d;
    end
  end

`ifndef SYNTHESIS
  a_fail_starts_discard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_valid_o && !res_o.crc_ok && !final_word) |=> disc_q)
    else $error("failing word did not start discard");
  a_discard_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (disc_q && !req_i.restart) |-> !res_valid_o)
    else $error("result produced while discarding");
  a_final_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_eff == PH_CHECK && final_word) |=> (cnt_q == '0 && !disc_q))
    else $error("counter not cleared after final word");
`endif

endmodule

// ===== design/crc8wc_out_stage.sv =====
// result register towards the consumer
`timescale 1ns / 1ps
module crc8wc_out_stage import crc8wc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic out_stall_i,
  output logic free_o,
  output logic out_valid_o,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== design/crc8_word_response_checker_top.sv =====
// top level: config register, input stage, framing and check, result stage
// a request is registered in the input stage, and its result then in the result stage
// throughput: one byte per cycle unless a stalled result blocks the single register pair
// bytes that yield no result leave the input stage even while the result stage stalls
// reset: control state and framing state cleared, words_per_response set to 2
`timescale 1ns / 1ps
module crc8_word_response_checker_top import crc8wc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       rx_byte_i,
  input  logic             restart_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [15:0]      word_value_o,
  output logic [CntW-1:0]  word_index_o,
  output logic             crc_ok_o,
  output logic             last_word_o
);

  logic [4:0] wpr_q, wpr_d;
  logic       cfg_wr;

  in_req_t    in_req;
  in_req_t    stage_req;
  logic       stage_valid;
  logic       advance;
  logic       res_valid;
  res_t       res;
  res_t       out_res;
  logic       out_free;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == AddrWpr);
  assign wpr_d  = cfg_wr ? pwdata[4:0] : wpr_q;
  assign prdata = (paddr == AddrWpr) ? DataW'(wpr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpr_q <= WprReset;
    end else begin
      wpr_q <= wpr_d;
    end
  end

  assign in_req.rx_byte = rx_byte_i;
  assign in_req.restart = restart_i;
  assign advance        = stage_valid && (!res_valid || out_free);

  crc8wc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_i      (in_req),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .req_o      (stage_req)
  );

  crc8wc_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .req_i       (stage_req),
    .wpr_i       (wpr_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  crc8wc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign word_value_o = out_res.word_value;
  assign word_index_o = out_res.word_index;
  assign crc_ok_o     = out_res.crc_ok;
  assign last_word_o  = out_res.last_word;

endmodule

// ===== dv/crc8_word_response_checker_chk.sv =====
// response word checker: crc helper, frame prediction, expected word queue and compare
`timescale 1ns / 1ps
package crc8wc_tb_pkg;
  import crc8wc_pkg::*;

  // bitwise msb-first form over both data bytes
  function automatic logic [7:0] word_crc(input logic [15:0] w);
    logic [7:0] r;
    logic       fb;
    r = CrcStart;
    for (int i = 15; i >= 0; i--) begin
      fb = r[7] ^ w[i];
      r  = {r[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [4:0] frame_len(input logic [4:0] cfg);
    if (cfg == 5'd0) begin
      return 5'd1;
    end
    if (cfg > WprCap) begin
      return WprCap;
    end
    return cfg;
  endfunction
endpackage

module crc8_word_response_checker_chk import crc8wc_pkg::*, crc8wc_tb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             restart_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [15:0]      word_value_i,
  input  logic [CntW-1:0]  word_index_i,
  input  logic             crc_ok_i,
  input  logic             last_word_i,
  output int               fail_count_o,
  output int               waiting_o,
  output int               words_checked_o,
  output int               bad_words_o
);

  logic [4:0]      words_cfg;
  phase_e          frame_phase;
  logic [CntW-1:0] word_cnt;
  logic [7:0]      high_hold;
  logic [7:0]      low_hold;
  logic            dropping;
  res_t            expected_words[$];
  int              fails;
  int              waiting;
  int              words_checked;
  int              bad_words;

  assign fail_count_o    = fails;
  assign waiting_o       = waiting;
  assign words_checked_o = words_checked;
  assign bad_words_o     = bad_words;

  task automatic take_byte(input logic [7:0] b, input logic rs);
    logic [4:0] n;
    logic       final_w;
    logic       ok;
    res_t       r;
    n = frame_len(words_cfg);
    if (rs) begin
      frame_phase = PH_HIGH;
      word_cnt    = '0;
      dropping    = 1'b0;
    end
    case (frame_phase)
      PH_LOW: begin
        low_hold    = b;
        frame_phase = PH_CHECK;
      end
      PH_CHECK: begin
        frame_phase = PH_HIGH;
        final_w     = ({1'b0, word_cnt} + 5'd1) >= n;
        if (!dropping) begin
          r.word_value = {high_hold, low_hold};
          ok = (word_crc(r.word_value) == b)
               || (r.word_value == ErasedWord && b == ErasedCheck);
          r.word_index = word_cnt;
          r.crc_ok     = ok;
          r.last_word  = final_w || !ok;
          expected_words.push_back(r);
          if (!ok && !final_w) begin
            dropping = 1'b1;
          end
        end
        if (final_w) begin
          word_cnt = '0;
          dropping = 1'b0;
        end else begin
          word_cnt = word_cnt + 1'b1;
        end
      end
      default: begin
        high_hold   = b;
        frame_phase = PH_LOW;
      end
    endcase
  endtask

  task automatic mismatch(input string what, input logic [15:0] exp_v, input logic [15:0] act_v);
    fails++;
    if (fails <= 10) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
    end
  endtask

  task automatic check_word();
    res_t e;
    words_checked++;
    if (!crc_ok_i) begin
      bad_words++;
    end
    if (expected_words.size() == 0) begin
      fails++;
      if (fails <= 10) begin
        $display("%0t: word %0h index %0d arrived with nothing expected",
                 $time, word_value_i, word_index_i);
      end
    end else begin
      e = expected_words.pop_front();
      if (word_value_i !== e.word_value) begin
        mismatch("word_value", e.word_value, word_value_i);
      end
      if (word_index_i !== e.word_index) begin
        mismatch("word_index", 16'(e.word_index), 16'(word_index_i));
      end
      if (crc_ok_i !== e.crc_ok) begin
        mismatch("crc_ok", 16'(e.crc_ok), 16'(crc_ok_i));
      end
      if (last_word_i !== e.last_word) begin
        mismatch("last_word", 16'(e.last_word), 16'(last_word_i));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_cfg   = WprReset;
      frame_phase = PH_HIGH;
      word_cnt    = '0;
      high_hold   = '0;
      low_hold    = '0;
      dropping    = 1'b0;
      expected_words.delete();
      waiting <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_word();
      end
      if (in_valid_i && !in_stall_i) begin
        take_byte(rx_byte_i, restart_i);
      end
      if (psel && penable && pwrite && pready && paddr == AddrWpr) begin
        words_cfg = pwdata[4:0];
      end
      waiting <= expected_words.size();
    end
  end

  initial begin
    fails         = 0;
    words_checked = 0;
    bad_words     = 0;
  end

endmodule

// ===== dv/crc8_word_response_checker_top_tb.sv =====
// testbench top: clock, reset, register writes, byte requests, idling and verdict
`timescale 1ns / 1ps
module crc8_word_response_checker_top_tb;
  import crc8wc_pkg::*;
  import crc8wc_tb_pkg::*;

  localparam int         StallLimit = 2000;
  localparam int         PhaseBytes = 100;
  localparam logic [4:0] Settings [8] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd3, 5'd7, 5'd2};

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [AddrW-1:0] paddr       = '0;
  logic [DataW-1:0] pwdata      = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [7:0]       rx_byte_i   = '0;
  logic             restart_i   = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [15:0]      word_value_o;
  logic [CntW-1:0]  word_index_o;
  logic             crc_ok_o;
  logic             last_word_o;

  int         fail_count;
  int         waiting;
  int         words_checked;
  int         bad_words;
  int         bytes_sent    = 0;
  int         settings_used = 0;
  int         idle_run      = 0;
  int         stall_left    = 0;
  logic       send_gaps     = 1'b0;
  logic       stall_gaps    = 1'b0;
  logic       framed        = 1'b0;
  logic [4:0] frame_words;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  crc8_word_response_checker_top dut (.*);

  crc8_word_response_checker_chk u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .restart_i       (restart_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .word_value_i    (word_value_o),
    .word_index_i    (word_index_o),
    .crc_ok_i        (crc_ok_o),
    .last_word_i     (last_word_o),
    .fail_count_o    (fail_count),
    .waiting_o       (waiting),
    .words_checked_o (words_checked),
    .bad_words_o     (bad_words)
  );

  always @(posedge clk_i) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end else if (stall_gaps && $urandom_range(0, 9) == 0) begin
      stall_left  <= $urandom_range(1, 18);
      out_stall_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (psel && penable && pwrite && pready)) begin
      idle_run <= 0;
    end else if (idle_run >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic rs);
    if (send_gaps && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    restart_i  <= rs;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [15:0] w, input logic [7:0] chk, input logic rs);
    send_byte(w[15:8], rs);
    send_byte(w[7:0], 1'b0);
    send_byte(chk, 1'b0);
  endtask

  // wait until every expected word has come out, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_words(input logic [4:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrWpr;
    pwdata  <= DataW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    psel        <= 1'b0;
    penable     <= 1'b0;
    frame_words = frame_len(v);
    settings_used++;
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: begin
        return ErasedWord;
      end
      1: begin
        return 16'h0000;
      end
      default: begin
        return 16'($urandom);
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_check(input logic [15:0] w);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (w == ErasedWord && roll < 8) begin
      return ErasedCheck;
    end
    if (roll < 17) begin
      return word_crc(w);
    end
    if (roll < 19) begin
      return word_crc(w) ^ (8'h01 << $urandom_range(0, 7));
    end
    return 8'($urandom);
  endfunction

  task automatic send_response(input logic rs);
    logic [15:0] w;
    for (int i = 0; i < frame_words; i++) begin
      w = pick_word();
      send_word(w, pick_check(w), rs && i == 0);
    end
  endtask

  // truncated or scrambled response with stray restarts
  task automatic send_noise();
    int unsigned len;
    len = $urandom_range(1, 8);
    repeat (len) send_byte(8'($urandom), $urandom_range(0, 5) == 0);
  endtask

  task automatic random_bytes(input int budget);
    int first;
    first = bytes_sent;
    while (bytes_sent - first < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
        framed = 1'b0;
      end else begin
        send_response(!framed || $urandom_range(0, 1) == 1);
        framed = 1'b1;
      end
    end
  endtask

  initial begin
    frame_words = frame_len(WprReset);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // good word, then erased pattern closing the response
    send_word(16'h0000, word_crc(16'h0000), 1'b1);
    send_word(ErasedWord, ErasedCheck, 1'b0);
    // failing first word, rest of response dropped
    send_word(16'h8001, word_crc(16'h8001) ^ 8'h01, 1'b0);
    send_word(16'h1234, word_crc(16'h1234), 1'b0);
    // failure on the final word
    send_word(16'hFF00, word_crc(16'hFF00), 1'b1);
    send_word(16'h00FF, word_crc(16'h00FF) ^ 8'hFF, 1'b0);
    // restart in the middle of a word
    send_byte(8'h12, 1'b1);
    send_byte(8'h34, 1'b0);
    send_word(16'hABCD, word_crc(16'hABCD), 1'b1);
    drain();

    // shrink the count while the word counter is already past it
    write_words(5'd16);
    send_word(16'h0F0F, word_crc(16'h0F0F), 1'b1);
    send_word(16'hF0F0, word_crc(16'hF0F0), 1'b0);
    send_word(16'h7FFE, word_crc(16'h7FFE), 1'b0);
    drain();
    write_words(5'd2);
    send_word(16'h5A5A, word_crc(16'h5A5A), 1'b0);
    framed = 1'b1;

    foreach (Settings[i]) begin
      drain();
      send_gaps  = (i % 3 != 1) && (i != 7);
      stall_gaps = (i % 3 != 2) && (i != 7);
      write_words(Settings[i]);
      random_bytes(PhaseBytes / 2);
      if (i == 3) begin
        drain();
      end
      random_bytes(PhaseBytes / 2);
    end
    drain();

    $display("%0d bytes sent under %0d word-count settings", bytes_sent, settings_used);
    $display("%0d words checked, %0d of them flagged as bad crc", words_checked, bad_words);
    if (fail_count == 0 && waiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
